@@ rtl/assert_macros.svh @@
// Assertion helpers for the frame encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication checked at every clock edge outside reset.
`define RFSW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define RFSW_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define RFSW_ASSERT(lbl, clk, rst_n, prop, msg)
`define RFSW_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

@@ rtl/rfsw_pkg.sv @@
`default_nettype none

package rfsw_pkg;

    localparam int unsigned FRAME_BITS = 26;
    localparam int unsigned CNT_W      = 5;

    localparam logic [4:0]  PREAMBLE     = 5'h19;
    localparam logic [3:0]  CSUM_SEED    = 4'h9;
    localparam logic [15:0] ONE_PULSE_US  = 16'd600;
    localparam logic [15:0] ZERO_PULSE_US = 16'd1300;
    localparam logic [15:0] GAP_US        = 16'd3400;
    localparam logic [15:0] LAST_GAP_US   = 16'd33400;  // gap plus 30000 trailer
    localparam logic [15:0] ERR_US        = 16'd0;

    localparam logic [2:0]  CHAN_ONE = 3'd1;
    localparam logic [2:0]  CHAN_TWO = 3'd2;
    localparam logic [2:0]  CHAN_BAD = 3'd4;
    localparam logic [2:0]  CHAN_ALL = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PULSE,
        ST_GAP,
        ST_ERR
    } rfsw_state_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic emit_pulse;
        logic emit_gap;
    } rfsw_cmd_t;

    typedef struct packed {
        logic in_bad;
        logic last_bit;
    } rfsw_stat_t;

endpackage

`default_nettype wire

@@ rtl/rfsw_dp.sv @@
`default_nettype none

module rfsw_dp
    import rfsw_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  system_code,
    input  wire logic [2:0]  channel_number,
    input  wire logic        switch_on,
    input  wire rfsw_cmd_t   cmd,
    output rfsw_stat_t       stat,
    output logic [15:0]      duration_us
);

    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [7:0]            cmd_byte;
    logic [3:0]            csum;
    logic                  inv;

    always_comb
    begin
        inv      = (channel_number == CHAN_ONE) || (channel_number == CHAN_TWO);
        cmd_byte = {switch_on ^ inv, channel_number, 1'b0, ~switch_on, 2'b00};
        csum     = CSUM_SEED + system_code[3:0] + system_code[7:4]
                 + cmd_byte[3:0] + cmd_byte[7:4];
        stat.in_bad   = (channel_number == CHAN_BAD) || (channel_number > CHAN_ALL);
        stat.last_bit = (cnt_reg == CNT_W'(FRAME_BITS - 1));

        frame_next = frame_reg;
        cnt_next   = cnt_reg;
        if (cmd.load)
        begin
            frame_next = {1'b0, PREAMBLE, system_code, cmd_byte, csum};
            cnt_next   = '0;
        end
        else if (cmd.shift)
        begin
            frame_next = {frame_reg[FRAME_BITS-2:0], 1'b0};
            cnt_next   = cnt_reg + 1'b1;
        end

        if (cmd.emit_pulse)
            duration_us = frame_reg[FRAME_BITS-1] ? ONE_PULSE_US : ZERO_PULSE_US;
        else if (cmd.emit_gap)
            duration_us = stat.last_bit ? LAST_GAP_US : GAP_US;
        else
            duration_us = ERR_US;
    end

    // frame is payload, counter is control
    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

endmodule

`default_nettype wire

@@ rtl/rfsw_ctrl.sv @@
`default_nettype none

module rfsw_ctrl
    import rfsw_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire rfsw_stat_t  stat,
    output rfsw_cmd_t        cmd,
    output logic             busy,
    output logic             strobe,
    output logic             gap_phase,
    output logic             bad_channel,
    output logic             end_of_frame
);

    rfsw_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        busy         = 1'b1;
        strobe       = 1'b0;
        gap_phase    = 1'b0;
        bad_channel  = 1'b0;
        end_of_frame = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.in_bad ? ST_ERR : ST_PULSE;
                end
            end
            ST_PULSE:
            begin
                cmd.emit_pulse = 1'b1;
                strobe         = 1'b1;
                state_next     = ST_GAP;
            end
            ST_GAP:
            begin
                cmd.emit_gap = 1'b1;
                strobe       = 1'b1;
                gap_phase    = 1'b1;
                end_of_frame = stat.last_bit;
                if (stat.last_bit)
                    state_next = ST_IDLE;
                else
                begin
                    cmd.shift  = 1'b1;
                    state_next = ST_PULSE;
                end
            end
            ST_ERR:
            begin
                // datapath drives zero duration when no emit command is set
                strobe       = 1'b1;
                bad_channel  = 1'b1;
                end_of_frame = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/rf_switch_pulse_frame_encoder_top.sv @@
`default_nettype none
// Channel   | Signals                                        | Handshake
// ----------+------------------------------------------------+------------------------
// command   | system_code, channel_number, switch_on         | start & !busy
// result    | duration_us, gap_phase, bad_channel, end_of_frame | strobe, one cycle each
//
// A good command gives a pulse result and a gap result per frame bit, on
// consecutive cycles starting the cycle after acceptance; busy drops after the last one.
// A rejected channel gives one result the cycle after acceptance.
// The results come from the pulse/gap sequencer walking the 26-bit frame register.
// Reset (rst_n, async, active low) returns the sequencer to idle.
// The receiver cannot stall: every strobed result is taken in its cycle.

`include "assert_macros.svh"

module rf_switch_pulse_frame_encoder_top
    import rfsw_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [7:0]  system_code,
    input  wire logic [2:0]  channel_number,
    input  wire logic        switch_on,
    output logic             strobe,
    output logic [15:0]      duration_us,
    output logic             gap_phase,
    output logic             bad_channel,
    output logic             end_of_frame
);

    rfsw_cmd_t  cmd;   // controller -> datapath
    rfsw_stat_t stat;  // datapath -> controller

    logic pulse_cyc;   // first duration of a good bit on the result port
    logic err_shape;   // fields that an error result must not show

    assign pulse_cyc = strobe && !gap_phase && !bad_channel;
    assign err_shape = !end_of_frame || (duration_us != ERR_US);

    rfsw_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .stat         (stat),
        .cmd          (cmd),
        .busy         (busy),
        .strobe       (strobe),
        .gap_phase    (gap_phase),
        .bad_channel  (bad_channel),
        .end_of_frame (end_of_frame)
    );

    // frame build, bit walk and duration select
    rfsw_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .system_code    (system_code),
        .channel_number (channel_number),
        .switch_on      (switch_on),
        .cmd            (cmd),
        .stat           (stat),
        .duration_us    (duration_us)
    );

    // results only while a transaction is in flight
    `RFSW_ASSERT(a_strobe_busy, clk, rst_n, strobe |-> busy, "result outside transaction")
    // a pulse is always followed by its gap
    `RFSW_ASSERT(a_pulse_gap, clk, rst_n, pulse_cyc |=> (strobe && gap_phase), "pulse without gap")
    // last result frees the block next cycle
    `RFSW_ASSERT(a_eof_idle, clk, rst_n, (strobe && end_of_frame) |=> !busy, "busy after end of frame")
    // error result carries zero duration and closes the run
    `RFSW_NEVER(a_err_form, clk, rst_n, bad_channel && err_shape, "bad error result")

endmodule

`default_nettype wire

@@ sim/rf_switch_pulse_frame_encoder_top_tb.sv @@
`timescale 1ns / 100ps

module rf_switch_pulse_frame_encoder_top_tb;
    import rfsw_pkg::*;

    // Channels that have no name in the package.
    localparam logic [2:0] CHAN_ZERO    = 3'd0;
    localparam logic [2:0] CHAN_THREE   = 3'd3;
    localparam logic [2:0] CHAN_RSVD_LO = 3'd6;
    localparam logic [2:0] CHAN_RSVD_HI = 3'd7;

    localparam int NUM_ROWS     = 18;
    localparam int NUM_RANDOM   = 300;
    localparam int IDLE_PCT     = 23;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 200000;

    // How a transaction is checked: by the predictor, against a frame word
    // typed into the table, or as a rejected channel.
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_FRAME,
        CHK_REJECT
    } check_kind_t;

    typedef struct packed {
        logic [7:0]  sys;
        logic [2:0]  chan;
        logic        cmd_on;
        check_kind_t kind;
        logic [25:0] frame;
    } cmd_row_t;

    typedef struct packed {
        logic [15:0] dur;
        logic        gap;
        logic        bad;
        logic        eof;
    } pulse_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [7:0]  system_code;
    logic [2:0]  channel_number;
    logic        switch_on;
    logic        strobe;
    logic [15:0] duration_us;
    logic        gap_phase;
    logic        bad_channel;
    logic        end_of_frame;

    // Durations still owed by the block, oldest first.
    pulse_t      expected_pulses[$];

    // Check mode of the transaction currently offered on the command port.
    check_kind_t offered_kind;
    logic [25:0] offered_frame;

    int          error_count;
    int          frames_sent;
    int          rejects_sent;
    int          pulses_checked;
    int          cycle_count;

    cmd_row_t    directed_rows [NUM_ROWS];

    rf_switch_pulse_frame_encoder_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .system_code    (system_code),
        .channel_number (channel_number),
        .switch_on      (switch_on),
        .strobe         (strobe),
        .duration_us    (duration_us),
        .gap_phase      (gap_phase),
        .bad_channel    (bad_channel),
        .end_of_frame   (end_of_frame)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic bit channel_rejected(input logic [2:0] chan);
        return (chan == CHAN_BAD) || (chan > CHAN_ALL);
    endfunction

    // 26-bit frame: zero, preamble, system code, command byte, checksum.
    function automatic logic [25:0] encode_frame(input logic [7:0] sys,
                                                 input logic [2:0] chan,
                                                 input logic cmd_on);
        logic [7:0] cmd;
        logic [3:0] csum;
        cmd = {cmd_on, chan, 1'b0, ~cmd_on, 2'b00};
        // channels 1 and 2 carry the on bit inverted
        if (chan == CHAN_ONE || chan == CHAN_TWO)
            cmd[7] = ~cmd[7];
        // only the low nibble survives, so the nibbles can be summed directly
        csum = CSUM_SEED + sys[3:0] + sys[7:4] + cmd[3:0] + cmd[7:4];
        return {1'b0, PREAMBLE, sys, cmd, csum};
    endfunction

    // MSB first, a pulse and a gap per bit; the last gap carries the trailer.
    function automatic void queue_frame_pulses(input logic [25:0] frame);
        for (int i = FRAME_BITS - 1; i >= 0; i--)
        begin
            expected_pulses.push_back({frame[i] ? ONE_PULSE_US : ZERO_PULSE_US,
                                       1'b0, 1'b0, 1'b0});
            expected_pulses.push_back({(i == 0) ? LAST_GAP_US : GAP_US,
                                       1'b1, 1'b0, (i == 0) ? 1'b1 : 1'b0});
        end
    endfunction

    // Monitor: results are checked before a new transaction is queued, so a
    // result in the acceptance cycle can only match older expectations.
    always @(posedge clk)
    begin
        pulse_t want;
        if (rst_n)
        begin
            if (strobe)
            begin
                if (expected_pulses.size() == 0)
                begin
                    $error("result with nothing expected: duration_us=%0d", duration_us);
                    error_count++;
                end
                else
                begin
                    want = expected_pulses.pop_front();
                    pulses_checked++;
                    if (duration_us !== want.dur)
                    begin
                        $error("duration_us: expected %0d, got %0d", want.dur, duration_us);
                        error_count++;
                    end
                    if (gap_phase !== want.gap)
                    begin
                        $error("gap_phase: expected %0b, got %0b", want.gap, gap_phase);
                        error_count++;
                    end
                    if (bad_channel !== want.bad)
                    begin
                        $error("bad_channel: expected %0b, got %0b", want.bad, bad_channel);
                        error_count++;
                    end
                    if (end_of_frame !== want.eof)
                    begin
                        $error("end_of_frame: expected %0b, got %0b", want.eof, end_of_frame);
                        error_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                case (offered_kind)
                    CHK_FRAME:
                    begin
                        queue_frame_pulses(offered_frame);
                        frames_sent++;
                    end
                    CHK_REJECT:
                    begin
                        expected_pulses.push_back({ERR_US, 1'b0, 1'b1, 1'b1});
                        rejects_sent++;
                    end
                    default:
                    begin
                        if (channel_rejected(channel_number))
                        begin
                            expected_pulses.push_back({ERR_US, 1'b0, 1'b1, 1'b1});
                            rejects_sent++;
                        end
                        else
                        begin
                            queue_frame_pulses(encode_frame(system_code, channel_number,
                                                            switch_on));
                            frames_sent++;
                        end
                    end
                endcase
            end
        end
    end

    // Watchdog: well beyond the run time of all 318 transactions plus idle gaps.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_pulses.size());
            $display("rf_switch_pulse_frame_encoder_top test failed");
            $finish;
        end
    end

    // Offers one transaction at a falling edge and holds it until accepted.
    // Idle cycles before it carry random junk with start low.
    task automatic drive_command(input logic [7:0] sys, input logic [2:0] chan,
                                 input logic cmd_on, input check_kind_t kind,
                                 input logic [25:0] frame, input bit allow_idle);
        if (allow_idle)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                @(negedge clk);
                start          <= 1'b0;
                system_code    <= 8'($urandom);
                channel_number <= 3'($urandom);
                switch_on      <= 1'($urandom);
            end
        end
        @(negedge clk);
        system_code    <= sys;
        channel_number <= chan;
        switch_on      <= cmd_on;
        start          <= 1'b1;
        offered_kind  = kind;
        offered_frame = frame;
        do
            @(posedge clk);
        while (busy);
    endtask

    initial
    begin
        logic [7:0] sys;
        logic [2:0] chan;
        int         pick;

        // Typed frames: all-zero code on channel 0 off, all-ones code on the
        // all-channels group on, and channel 1 where bit 7 gets inverted.
        directed_rows = '{
            '{8'h00, CHAN_ZERO,    1'b0, CHK_FRAME,  26'h190004D},
            '{8'hFF, CHAN_ALL,     1'b1, CHK_FRAME,  26'h19FFD04},
            '{8'h00, CHAN_ONE,     1'b1, CHK_FRAME,  26'h190010A},
            '{8'h5A, CHAN_BAD,     1'b1, CHK_REJECT, 26'h0},
            '{8'hFF, CHAN_RSVD_LO, 1'b0, CHK_REJECT, 26'h0},
            '{8'h00, CHAN_RSVD_HI, 1'b1, CHK_REJECT, 26'h0},
            '{8'h55, CHAN_ZERO,    1'b1, CHK_MODEL,  26'h0},
            '{8'hAA, CHAN_ONE,     1'b0, CHK_MODEL,  26'h0},
            '{8'h0F, CHAN_TWO,     1'b1, CHK_MODEL,  26'h0},
            '{8'hF0, CHAN_TWO,     1'b0, CHK_MODEL,  26'h0},
            '{8'h80, CHAN_THREE,   1'b1, CHK_MODEL,  26'h0},
            '{8'h01, CHAN_THREE,   1'b0, CHK_MODEL,  26'h0},
            '{8'h7F, CHAN_ALL,     1'b0, CHK_MODEL,  26'h0},
            '{8'hFF, CHAN_ZERO,    1'b1, CHK_MODEL,  26'h0},
            '{8'h00, CHAN_ALL,     1'b0, CHK_MODEL,  26'h0},
            '{8'hFF, CHAN_BAD,     1'b0, CHK_REJECT, 26'h0},
            '{8'h12, CHAN_ONE,     1'b0, CHK_MODEL,  26'h0},
            '{8'hC3, CHAN_RSVD_HI, 1'b0, CHK_MODEL,  26'h0}
        };

        error_count    = 0;
        frames_sent    = 0;
        rejects_sent   = 0;
        pulses_checked = 0;
        cycle_count    = 0;
        offered_kind   = CHK_MODEL;
        offered_frame  = '0;
        rst_n          = 1'b0;
        start          = 1'b0;
        system_code    = '0;
        channel_number = '0;
        switch_on      = 1'b0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < NUM_ROWS; r++)
            drive_command(directed_rows[r].sys, directed_rows[r].chan,
                          directed_rows[r].cmd_on, directed_rows[r].kind,
                          directed_rows[r].frame, 1'b1);

        // Mostly legal channels; a block of transactions runs back to back.
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            sys  = 8'($urandom);
            pick = $urandom_range(4);
            if ($urandom_range(99) < 15)
                chan = (pick < 2) ? CHAN_BAD : ((pick < 4) ? CHAN_RSVD_LO : CHAN_RSVD_HI);
            else
                chan = (pick == 4) ? CHAN_ALL : 3'(pick);
            drive_command(sys, chan, 1'($urandom), CHK_MODEL, '0,
                          !(n >= 100 && n < 180));
        end

        @(negedge clk);
        start <= 1'b0;

        while (expected_pulses.size() != 0)
            @(posedge clk);
        // Quiet period to catch stray strobes after the last frame.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_pulses.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_pulses.size());
            error_count++;
        end

        $display("Sent %0d frames and %0d rejected commands; %0d durations checked.",
                 frames_sent, rejects_sent, pulses_checked);
        $display("Mismatches: %0d", error_count);
        if (error_count == 0)
            $display("rf_switch_pulse_frame_encoder_top test passed");
        else
            $display("rf_switch_pulse_frame_encoder_top test failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/rfsw_pkg.sv
rtl/rfsw_dp.sv
rtl/rfsw_ctrl.sv
rtl/rf_switch_pulse_frame_encoder_top.sv
sim/rf_switch_pulse_frame_encoder_top_tb.sv
